>>> sv/assert_macros.svh
// Assertion macros used by the top level of the preset table tuner.
// Each macro expands to one labeled concurrent assertion clocked on clk, reset by arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/sptt_pkg.sv
// Package of the preset table tuner: transaction types, mode and register codes, constants.
// No dependencies; every module imports it.
package sptt_pkg;

	localparam logic [15:0] EMPTY_ENTRY  = 16'hFFFF;
	localparam logic [15:0] FREQ_MIN_RST = 16'd8750;
	localparam logic [15:0] FREQ_MAX_RST = 16'd10800;

	localparam logic [2:0] MODE_TUNE  = 3'd0;
	localparam logic [2:0] MODE_SCAN  = 3'd1;
	localparam logic [2:0] MODE_LOAD  = 3'd2;
	localparam logic [2:0] MODE_STORE = 3'd3;
	localparam logic [2:0] MODE_MONO  = 3'd4;

	localparam logic REG_FREQ_MIN = 1'b0;
	localparam logic REG_FREQ_MAX = 1'b1;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] freq_value;
		logic        direction;
		logic [5:0]  preset_index;
	} cmd_t;

	typedef struct packed {
		logic [15:0] cur_freq;
		logic        mono_on;
		logic [6:0]  station_num;
	} result_t;

	typedef struct packed {
		logic        shift;
		logic [15:0] tail;
	} ring_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EDIT,
		ST_FIND
	} state_t;

	typedef enum logic [1:0] {
		ED_SEARCH,
		ED_DELETE,
		ED_INSERT
	} edit_t;

	function automatic logic [15:0] wrap_freq(input logic [15:0] f, input logic [15:0] fmin,
			input logic [15:0] fmax);
		logic [15:0] r;
		r = f;
		if (r > fmax) begin
			r = fmin;
		end
		if (r < fmin) begin
			r = fmax;
		end
		return r;
	endfunction

endpackage

>>> sv/sorted_preset_table_tuner.sv
// Top level of the preset table tuner: APB register port, ring of table cells, walk controller.
// Depends on sptt_pkg, sptt_cell, sptt_ctrl and assert_macros.svh.
//
// Use: drive cmd and raise start while busy is low; the transaction is taken at that edge
// and busy rises in the next cycle. Commands: tune, scan stored, load preset, store or
// delete the current frequency, toggle mono.
// The table lives in a ring of STATION_COUNT cells that rotates one place per cycle while
// busy is high. A transaction makes two full turns: the first applies tune, scan, load or
// the store edit, the second searches the station number of the final frequency. done then
// pulses for one cycle with result valid. The next command can be taken in the done cycle;
// no new command is taken while busy is high.
// The receiver cannot stall: done is shown once, and result holds until the next
// transaction's find turn ends.
// freq_min (address 0) and freq_max (address 4) are written over APB; the user must write
// them only while busy is low, since the block itself does not enforce it.
// Reset clears every table entry to empty (0xFFFF) at once, sets the current frequency to
// the freq_min reset value, clears mono and restores both registers.
`include "assert_macros.svh"

module sorted_preset_table_tuner
	import sptt_pkg::*;
#(
	parameter int STATION_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        done,
	output result_t     result
);

	logic [15:0] freq_min_q;
	logic [15:0] freq_max_q;
	logic [15:0] cell_q [STATION_COUNT];
	ring_t       ring;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_min_q <= FREQ_MIN_RST;
			freq_max_q <= FREQ_MAX_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_FREQ_MIN: freq_min_q <= pwdata[15:0];
				REG_FREQ_MAX: freq_max_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FREQ_MIN: prdata = {16'b0, freq_min_q};
			REG_FREQ_MAX: prdata = {16'b0, freq_max_q};
			default:      prdata = '0;
		endcase
	end

	for (genvar k = 0; k < STATION_COUNT; k++) begin : g_cell
		logic [15:0] d;
		if (k == STATION_COUNT - 1) begin : g_tail
			assign d = ring.tail;
		end else begin : g_link
			assign d = cell_q[k+1];
		end
		sptt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ring.shift),
			.d      (d),
			.q      (cell_q[k])
		);
	end

	sptt_ctrl #(
		.STATION_COUNT (STATION_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.freq_min (freq_min_q),
		.freq_max (freq_max_q),
		.head     (cell_q[0]),
		.next     (cell_q[1]),
		.ring     (ring),
		.done     (done),
		.result   (result)
	);

	`ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`ASSERT_IMPLIES(a_done_idle, done, !busy, "result reported while still busy")
	`ASSERT_IMPLIES(a_done_past, done, $past(busy), "result without a transaction in flight")

endmodule

>>> sv/sptt_cell.sv
// One table cell of the preset ring: holds one stored frequency, takes its neighbor's on shift.
// Depends on sptt_pkg.
module sptt_cell
	import sptt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift,
	input  logic [15:0] d,
	output logic [15:0] q
);

	logic [15:0] entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= EMPTY_ENTRY;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

>>> sv/sptt_ctrl.sv
// Walk controller of the preset table tuner: rotates the cell ring twice per transaction,
// edits the stream on store, resolves scan/load, then finds the station number. Uses sptt_pkg.
module sptt_ctrl
	import sptt_pkg::*;
#(
	parameter int STATION_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	input  logic [15:0] freq_min,
	input  logic [15:0] freq_max,
	input  logic [15:0] head,
	input  logic [15:0] next,
	output ring_t       ring,
	output logic        done,
	output result_t     result
);

	localparam int IW  = $clog2(STATION_COUNT);
	localparam int IXW = (IW > 6) ? IW : 6;
	localparam int SW  = (IW + 1 > 7) ? IW + 1 : 7;

	state_t      state_q, state_d;
	logic [IW-1:0] step_q;
	cmd_t        cmd_q;
	logic [15:0] cur_q;
	logic        mono_q;
	logic [15:0] found_q, found_n;
	logic        apply_q, apply_n;
	logic        hit_q, hit_n;
	edit_t       edit_q;
	logic [15:0] carry_q;
	logic [6:0]  station_q, station_n;
	logic        stn_hit_q, stn_hit_n;
	logic        done_q;
	result_t     result_q;
	logic        last_step;
	logic        idx_hit;
	logic [15:0] tail_edit;
	logic [SW-1:0] pos;

	assign last_step = (step_q == IW'(STATION_COUNT - 1));
	assign idx_hit   = (IXW'(cmd_q.preset_index) == IXW'(step_q));
	assign pos       = SW'(step_q) + SW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EDIT;
				end
			end
			ST_EDIT: begin
				if (last_step) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				if (last_step) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (edit_q)
			ED_SEARCH: begin
				if (head < cur_q) begin
					tail_edit = head;
				end else if (head == cur_q) begin
					tail_edit = last_step ? EMPTY_ENTRY : next;
				end else begin
					tail_edit = cur_q;
				end
			end
			ED_DELETE: tail_edit = last_step ? EMPTY_ENTRY : next;
			ED_INSERT: tail_edit = carry_q;
			default:   tail_edit = head;
		endcase
		ring.shift = busy;
		ring.tail  = (state_q == ST_EDIT && cmd_q.mode == MODE_STORE) ? tail_edit : head;
	end

	always_comb begin
		found_n = found_q;
		apply_n = apply_q;
		hit_n   = hit_q;
		if (cmd_q.mode == MODE_SCAN && !hit_q && head != EMPTY_ENTRY) begin
			if (cmd_q.direction) begin
				if (head > cur_q) begin
					found_n = head;
					hit_n   = 1'b1;
				end
			end else begin
				if (head < cur_q) begin
					found_n = head;
				end else begin
					hit_n = 1'b1;
				end
			end
		end
		if (cmd_q.mode == MODE_LOAD && idx_hit && head != EMPTY_ENTRY) begin
			found_n = head;
			apply_n = 1'b1;
		end
		station_n = station_q;
		stn_hit_n = stn_hit_q;
		if (!stn_hit_q && head == cur_q) begin
			station_n = pos[6:0];
			stn_hit_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			cur_q  <= FREQ_MIN_RST;
			mono_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (start && cmd.mode == MODE_MONO) begin
						mono_q <= ~mono_q;
					end
				end
				ST_EDIT: begin
					step_q <= last_step ? '0 : step_q + IW'(1);
					if (last_step && apply_n) begin
						cur_q <= wrap_freq(found_n, freq_min, freq_max);
					end
				end
				ST_FIND: begin
					step_q <= last_step ? '0 : step_q + IW'(1);
					if (last_step) begin
						done_q <= 1'b1;
					end
				end
				default: step_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q   <= cmd;
				found_q <= (cmd.mode == MODE_TUNE) ? cmd.freq_value : cur_q;
				apply_q <= (cmd.mode == MODE_TUNE) || (cmd.mode == MODE_SCAN) ||
					(cmd.mode == MODE_MONO);
				hit_q   <= 1'b0;
				edit_q  <= ED_SEARCH;
			end
			ST_EDIT: begin
				found_q <= found_n;
				apply_q <= apply_n;
				hit_q   <= hit_n;
				if (cmd_q.mode == MODE_STORE) begin
					unique case (edit_q)
						ED_SEARCH: begin
							if (head == cur_q) begin
								edit_q <= ED_DELETE;
							end else if (head > cur_q) begin
								edit_q  <= ED_INSERT;
								carry_q <= head;
							end
						end
						ED_INSERT: carry_q <= head;
						default: ;
					endcase
				end
				station_q <= '0;
				stn_hit_q <= 1'b0;
			end
			ST_FIND: begin
				station_q <= station_n;
				stn_hit_q <= stn_hit_n;
				if (last_step) begin
					result_q.cur_freq    <= cur_q;
					result_q.mono_on     <= mono_q;
					result_q.station_num <= station_n;
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
